// ----- rtl/adsf_pkg.sv -----
// adsf_pkg: shared types, constants and register codes for the averaged
// dual-sensor follow drive. No dependencies; used by every file in rtl/.
package adsf_pkg;

  // Window geometry
  localparam int unsigned WINDOW    = 12;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned SAMPLE_MAX = (2 ** SAMPLE_W) - 1;
  localparam int unsigned SUM_W     = $clog2(WINDOW * SAMPLE_MAX + 1);

  // floor(sum / WINDOW) as multiply by rounded-up reciprocal and shift
  localparam int unsigned RECIP_SH  = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W   = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SH) + WINDOW - 1) / WINDOW);
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;

  // Drive law constants
  localparam int unsigned DRIVE_W        = 8;
  localparam int unsigned MAG_W          = 7;
  localparam int unsigned DRIVE_MAX      = 100;
  localparam int unsigned BACKOFF_DRIVE  = 50;
  localparam int unsigned FOLLOW_OFFSET  = 40;
  localparam int unsigned FOLLOW_GAIN    = 1052;
  localparam int unsigned FOLLOW_SCALE   = 1000;
  localparam int unsigned LUT_DEPTH      = 2 ** SAMPLE_W;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_LIMIT = 2'd0,
    REG_SEE_LIMIT  = 2'd1,
    REG_DEAD_BAND  = 2'd2
  } reg_idx_e;

  localparam logic [SAMPLE_W-1:0] NEAR_RESET = 8'd15;
  localparam logic [SAMPLE_W-1:0] SEE_RESET  = 8'd55;
  localparam logic [SAMPLE_W-1:0] BAND_RESET = 8'd5;

  // Drive mode codes
  typedef enum logic [2:0] {
    MODE_FOLLOW   = 3'd0,
    MODE_FORWARD  = 3'd1,
    MODE_BACKWARD = 3'd2,
    MODE_STOP     = 3'd3,
    MODE_SEEK     = 3'd4
  } mode_e;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 2 * SAMPLE_W;
  localparam int unsigned OUT_FIELDS_W = 2 * SAMPLE_W + 2 * DRIVE_W + 3;
  localparam int unsigned OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] left;
  } sample_pair_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] near_limit;
    logic [SAMPLE_W-1:0] see_limit;
    logic [SAMPLE_W-1:0] dead_band;
  } cfg_t;

  typedef struct packed {
    mode_e               mode;
    logic [DRIVE_W-1:0]  drive_c;
    logic [DRIVE_W-1:0]  drive_a;
  } drive_t;

  typedef logic [MAG_W-1:0] mag_lut_t [LUT_DEPTH];

endpackage

// ----- rtl/adsf_cell.sv -----
// adsf_cell: one window entry holding a left/right sample pair.
// Depends on adsf_pkg; chained by the top level into a shift line.
module adsf_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  adsf_pkg::sample_pair_t din_i,
  output adsf_pkg::sample_pair_t dout_o
);

  adsf_pkg::sample_pair_t pair_q;

  // take the neighbour's pair on every accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= '0;
    end else if (shift_i) begin
      pair_q <= din_i;
    end
  end

  assign dout_o = pair_q;

endmodule

// ----- rtl/adsf_drive.sv -----
// adsf_drive: picks motor drives and mode from the two window averages.
// Depends on adsf_pkg; purely combinational, registered by the top level.
module adsf_drive (
  input  logic [adsf_pkg::SAMPLE_W-1:0] left_avg_i,
  input  logic [adsf_pkg::SAMPLE_W-1:0] right_avg_i,
  input  adsf_pkg::cfg_t                cfg_i,
  output adsf_pkg::drive_t              drive_o
);

  typedef struct packed {
    adsf_pkg::mode_e                  code;
    logic [adsf_pkg::DRIVE_W-1:0]     drive;
  } follow_t;

  // magnitude table, saturated, built at elaboration
  function automatic adsf_pkg::mag_lut_t build_mag_lut();
    adsf_pkg::mag_lut_t lut;
    int unsigned        m;
    for (int unsigned i = 0; i < adsf_pkg::LUT_DEPTH; i++) begin
      m = ((i + adsf_pkg::FOLLOW_OFFSET) * adsf_pkg::FOLLOW_GAIN) / adsf_pkg::FOLLOW_SCALE;
      lut[i] = (m > adsf_pkg::DRIVE_MAX) ? adsf_pkg::MAG_W'(adsf_pkg::DRIVE_MAX)
                                         : adsf_pkg::MAG_W'(m);
    end
    return lut;
  endfunction

  localparam adsf_pkg::mag_lut_t MAG_LUT = build_mag_lut();

  // per-motor rule: back away if far, back off if near, else stop
  function automatic follow_t follow(input logic [adsf_pkg::SAMPLE_W-1:0] x,
                                     input logic [adsf_pkg::SAMPLE_W:0]   hi,
                                     input logic [adsf_pkg::SAMPLE_W-1:0] near);
    follow_t r;
    if ({1'b0, x} > hi) begin
      r.code  = adsf_pkg::MODE_FORWARD;
      r.drive = -{1'b0, MAG_LUT[x]};
    end else if (x < near) begin
      r.code  = adsf_pkg::MODE_BACKWARD;
      r.drive = adsf_pkg::DRIVE_W'(adsf_pkg::BACKOFF_DRIVE);
    end else begin
      r.code  = adsf_pkg::MODE_STOP;
      r.drive = '0;
    end
    return r;
  endfunction

  logic [adsf_pkg::SAMPLE_W:0]   hi;
  logic                          seek;
  logic                          both_far;
  logic [adsf_pkg::SAMPLE_W-1:0] x_a;
  logic [adsf_pkg::SAMPLE_W-1:0] x_c;
  follow_t                       fa;
  follow_t                       fc;

  // threshold and case flags
  always_comb begin
    hi       = {1'b0, cfg_i.near_limit} + {1'b0, cfg_i.dead_band};
    seek     = (left_avg_i > cfg_i.see_limit) && (right_avg_i > cfg_i.see_limit);
    both_far = ({1'b0, left_avg_i} > hi) && ({1'b0, right_avg_i} > hi);
    // crossover when both targets are far
    x_a      = both_far ? right_avg_i : left_avg_i;
    x_c      = both_far ? left_avg_i  : right_avg_i;
    fa       = follow(x_a, hi, cfg_i.near_limit);
    fc       = follow(x_c, hi, cfg_i.near_limit);
  end

  // final selection
  always_comb begin
    if (seek) begin
      drive_o.drive_a = -adsf_pkg::DRIVE_W'(adsf_pkg::DRIVE_MAX);
      drive_o.drive_c = adsf_pkg::DRIVE_W'(adsf_pkg::DRIVE_MAX);
      drive_o.mode    = adsf_pkg::MODE_SEEK;
    end else if (both_far) begin
      drive_o.drive_a = fa.drive;
      drive_o.drive_c = fc.drive;
      drive_o.mode    = adsf_pkg::MODE_FOLLOW;
    end else begin
      drive_o.drive_a = fa.drive;
      drive_o.drive_c = fc.drive;
      drive_o.mode    = fc.code;
    end
  end

endmodule

// ----- rtl/averaged_dual_sonar_follow_drive.sv -----
// averaged_dual_sonar_follow_drive: top level, window cell chain, running
// sums, averaging and output register. Depends on adsf_pkg, adsf_cell, adsf_drive.
//
// Usage
//   Input stream (s_axis_*): one transaction carries a left and a right
//   distance sample. Each sample enters a 12-entry shift line of cells; the
//   running sums are updated in the same cycle.
//   Output stream (m_axis_*): one result per input transaction, carrying both
//   window averages, the drives for motors A and C and the drive mode.
//   Configuration (cfg_*): near limit, see limit and dead band, written by
//   index; always ready. Write only while the block is idle.
//   Pipeline: a result passes the sum registers, then the reciprocal multiply
//   into the average registers, then drive selection into the output register.
//   Throughput: one transaction per cycle while the output is not stalled, set
//   by the sum update and the three-stage pipeline with per-stage handshake.
//   Reset: cells, sums and pipeline valids clear, registers take their
//   defaults (near 15, see 55, band 5).
//   Back-pressure: a stalled output holds its result; earlier stages keep
//   filling until the pipeline is full, then s_axis_tready drops.
module averaged_dual_sonar_follow_drive (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // fields from bit 0: left_sample[7:0], right_sample[15:8]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [adsf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // fields from bit 0: left_average[7:0], right_average[15:8], drive_a[23:16],
  // drive_c[31:24], mode[34:32], zero pad[39:35]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [adsf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [adsf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [adsf_pkg::SAMPLE_W-1:0]     cfg_data_i
);

  localparam int unsigned SW = adsf_pkg::SAMPLE_W;

  adsf_pkg::cfg_t         cfg_q;
  adsf_pkg::sample_pair_t new_pair;
  adsf_pkg::sample_pair_t cell_out [adsf_pkg::WINDOW];
  logic                   accept;

  logic                   v1_q, v2_q, out_v_q;
  logic                   out_ready, r2, r1;
  logic [adsf_pkg::SUM_W-1:0] lsum_q, lsum_d, rsum_q, rsum_d;
  logic [adsf_pkg::PROD_W-1:0] lprod, rprod;
  logic [SW-1:0]          lavg_q, ravg_q;
  adsf_pkg::drive_t       drive;
  logic [SW-1:0]          out_lavg_q, out_ravg_q;
  adsf_pkg::drive_t       out_drive_q;

  // per-stage handshake
  assign out_ready     = !out_v_q || m_axis_tready;
  assign r2            = !v2_q || out_ready;
  assign r1            = !v1_q || r2;
  assign s_axis_tready = r1;
  assign accept        = s_axis_tvalid && r1;

  assign new_pair.left  = s_axis_tdata[SW-1:0];
  assign new_pair.right = s_axis_tdata[2*SW-1:SW];

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_limit <= adsf_pkg::NEAR_RESET;
      cfg_q.see_limit  <= adsf_pkg::SEE_RESET;
      cfg_q.dead_band  <= adsf_pkg::BAND_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        adsf_pkg::REG_NEAR_LIMIT: cfg_q.near_limit <= cfg_data_i;
        adsf_pkg::REG_SEE_LIMIT:  cfg_q.see_limit  <= cfg_data_i;
        adsf_pkg::REG_DEAD_BAND:  cfg_q.dead_band  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // window shift line: newest at the top cell, oldest at cell 0
  for (genvar i = 0; i < adsf_pkg::WINDOW; i++) begin : g_cell
    adsf_pkg::sample_pair_t din;
    if (i == adsf_pkg::WINDOW - 1) begin : g_head
      assign din = new_pair;
    end else begin : g_link
      assign din = cell_out[i+1];
    end
    adsf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .din_i   (din),
      .dout_o  (cell_out[i])
    );
  end

  // running sums: drop the oldest, add the newest
  assign lsum_d = lsum_q - adsf_pkg::SUM_W'(cell_out[0].left)
                         + adsf_pkg::SUM_W'(new_pair.left);
  assign rsum_d = rsum_q - adsf_pkg::SUM_W'(cell_out[0].right)
                         + adsf_pkg::SUM_W'(new_pair.right);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsum_q <= '0;
      rsum_q <= '0;
    end else if (accept) begin
      lsum_q <= lsum_d;
      rsum_q <= rsum_d;
    end
  end

  // stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (r1) begin
      v1_q <= s_axis_tvalid;
    end
  end

  // averages by reciprocal multiply
  assign lprod = adsf_pkg::PROD_W'(lsum_q) * adsf_pkg::PROD_W'(adsf_pkg::RECIP);
  assign rprod = adsf_pkg::PROD_W'(rsum_q) * adsf_pkg::PROD_W'(adsf_pkg::RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (r2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      lavg_q <= lprod[adsf_pkg::RECIP_SH +: SW];
      ravg_q <= rprod[adsf_pkg::RECIP_SH +: SW];
    end
  end

  // drive decision
  adsf_drive u_drive (
    .left_avg_i  (lavg_q),
    .right_avg_i (ravg_q),
    .cfg_i       (cfg_q),
    .drive_o     (drive)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && v2_q) begin
      out_lavg_q  <= lavg_q;
      out_ravg_q  <= ravg_q;
      out_drive_q <= drive;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = adsf_pkg::OUT_DATA_W'({out_drive_q.mode, out_drive_q.drive_c,
                                                 out_drive_q.drive_a, out_ravg_q,
                                                 out_lavg_q});

endmodule

// ----- rtl/adsf_checker.sv -----
// adsf_checker: port-level assertions for the follow drive top level.
// Depends on adsf_pkg; attached to the top level by the bind below.
module adsf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [adsf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic signed [7:0] drv_a;
  logic signed [7:0] drv_c;
  logic [2:0]        mode;

  assign drv_a = m_axis_tdata[23:16];
  assign drv_c = m_axis_tdata[31:24];
  assign mode  = m_axis_tdata[34:32];

  // no result offered while in reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result offered during reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // drives stay saturated
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> drv_a >= -8'sd100 && drv_a <= 8'sd100
                      && drv_c >= -8'sd100 && drv_c <= 8'sd100)
    else $error("drive out of range");

  // seek mode drives fixed, both-follow mode backs away on both motors
  a_seek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mode == adsf_pkg::MODE_SEEK |-> drv_a == -8'sd100 && drv_c == 8'sd100)
    else $error("seek drive mismatch");

  a_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mode == adsf_pkg::MODE_FOLLOW |-> drv_a < 8'sd0 && drv_c < 8'sd0)
    else $error("follow drive not reversing");

endmodule

bind averaged_dual_sonar_follow_drive adsf_checker u_adsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
